// ----- src/ffba_pkg.sv -----
// ----------------------------------------------------------------------------
// ffba_pkg
// shared types and constants of the first-fit block allocator
// ----------------------------------------------------------------------------
package ffba_pkg;

    // address space of the heap
    localparam int          ADDR_BITS = 32;
    localparam logic [63:0] ADDR_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - ADDR_BITS);

    // width of a new break before the range checks
    localparam int NB_W = 34;

    // beat widths
    localparam int IN_DATA_W  = 96;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 128;

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REQUEST = 2'd2;

    localparam logic [31:0] HEAP_BASE_RST   = 32'd4096;
    localparam logic [31:0] HEAP_LIMIT_RST  = 32'd1048576;
    localparam logic [31:0] MAX_REQUEST_RST = 32'(10 << 8);

    // operation codes
    localparam logic [1:0] FN_ALLOC   = 2'd0;
    localparam logic [1:0] FN_CALLOC  = 2'd1;
    localparam logic [1:0] FN_FREE    = 2'd2;
    localparam logic [1:0] FN_REALLOC = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE   = 3'd1;
    localparam logic [2:0] ST_EXHAUSTED  = 3'd2;
    localparam logic [2:0] ST_TABLE_FULL = 3'd3;
    localparam logic [2:0] ST_UNKNOWN    = 3'd4;

    // one entry of the block table
    typedef struct packed {
        logic        free;
        logic [31:0] size;
        logic [31:0] base;
    } blk_entry_t;

    // request beat, last field lowest
    typedef struct packed {
        logic [31:0] user_addr;
        logic [31:0] elem_count;
        logic [31:0] req_size;
    } req_beat_t;

    // result beat, last field lowest
    typedef struct packed {
        logic [2:0]  pad;
        logic [11:0] header_bytes;
        logic [31:0] total_bytes;
        logic [6:0]  total_blocks;
        logic [31:0] free_bytes;
        logic [6:0]  free_blocks;
        logic [2:0]  status;
        logic [31:0] result_addr;
    } res_beat_t;

endpackage

// ----- src/first_fit_block_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit
// first-fit heap allocator with a block table in ram and running statistics
// ----------------------------------------------------------------------------
// Requests come in on the s_ channel: s_tuser carries the operation (alloc,
// calloc, free, realloc), s_tdata the size, element count and user address.
// Each request gives one result beat on the m_ channel with the returned
// address, a status and the heap statistics after the request.
// Configuration registers are written through cfg_wr_en/cfg_addr/cfg_wdata;
// the user must write them only while no request is in flight, which the
// block itself does not enforce. Writing the heap base also reloads the
// break while the table is empty.
// A request is worked by a sequencer around one table ram that is read one
// entry per cycle. A request takes longer the more blocks the table scan
// passes; calloc adds a step for the product, and a realloc that moves a
// block scans the table twice, once for the old block and once for a new one.
// s_tready is high only while the sequencer is idle; one request is worked
// at a time. The result sits in an output register, so the next request is
// taken while a result waits; a stalled m_ side holds the sequencer at its
// last step until the result register is free.
// Reset clears the table count, statistics and break (to the reset heap
// base) at once; the table ram needs no clearing pass.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request: tdata = req_size, elem_count, user_addr (from bit 0)
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ffba_pkg::IN_DATA_W-1:0]      s_tdata,
    // request: tuser = func
    input  logic [ffba_pkg::IN_USER_W-1:0]      s_tuser,
    // result: tdata = result_addr, status, free_blocks, free_bytes,
    // total_blocks, total_bytes, header_bytes, zero pad (from bit 0)
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ffba_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [ffba_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [ffba_pkg::CFG_W-1:0]          cfg_wdata
);

    import ffba_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int ENT_W = $bits(blk_entry_t);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_MUL      = 3'd1;
    localparam logic [2:0] S_CHECK    = 3'd2;
    localparam logic [2:0] S_SCAN     = 3'd3;
    localparam logic [2:0] S_REUSE    = 3'd4;
    localparam logic [2:0] S_APPEND   = 3'd5;
    localparam logic [2:0] S_FREE_OLD = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    localparam logic MODE_ALLOC  = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // control state
    logic [2:0]       state_reg, state_next;
    logic [31:0]      heap_base_reg, heap_base_next;
    logic [31:0]      heap_limit_reg, heap_limit_next;
    logic [31:0]      max_req_reg, max_req_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      brk_reg, brk_next;
    logic [CNT_W-1:0] free_blk_reg, free_blk_next;
    logic [31:0]      free_byte_reg, free_byte_next;
    logic [31:0]      byte_tot_reg, byte_tot_next;
    logic             mode_reg, mode_next;
    logic             relo_reg, relo_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic             pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;

    // payload
    logic [1:0]       func_reg, func_next;
    logic [31:0]      size_reg, size_next;
    logic [31:0]      cnt_reg, cnt_next;
    logic [31:0]      ua_reg, ua_next;
    logic             ovf_reg, ovf_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [31:0]      hit_base_reg, hit_base_next;
    logic [31:0]      hit_size_reg, hit_size_next;
    logic [IDX_W-1:0] old_idx_reg, old_idx_next;
    logic [31:0]      old_base_reg, old_base_next;
    logic [31:0]      old_size_reg, old_size_next;
    logic             old_free_reg, old_free_next;
    logic [31:0]      addr_reg, addr_next;
    logic [2:0]       st_reg, st_next;
    res_beat_t        out_data_reg, out_data_next;

    // table ram
    logic             ram_wr_en;
    logic [IDX_W-1:0] ram_wr_addr;
    blk_entry_t       ram_wr_data;
    logic             ram_rd_en;
    logic [IDX_W-1:0] ram_rd_addr;
    logic [ENT_W-1:0] ram_rd_data;

    // datapath
    req_beat_t        req;
    blk_entry_t       ent;
    logic [31:0]      ent_daddr;
    logic             size_ok;
    logic             hit;
    logic             more;
    logic [63:0]      prod;
    logic [NB_W-1:0]  new_brk;

    ffba_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign req       = req_beat_t'(s_tdata);
    assign ent       = blk_entry_t'(ram_rd_data);
    assign ent_daddr = (ent.base + 32'(HEADER_BYTES)) & ADDR_MASK[31:0];
    assign size_ok   = !ovf_reg && (size_reg != 32'd0) && (size_reg <= max_req_reg);
    assign more      = scan_idx_reg < count_reg;
    assign prod      = size_reg * cnt_reg;
    assign new_brk   = NB_W'(brk_reg) + NB_W'(size_reg) + NB_W'(HEADER_BYTES);

    always_comb
    begin
        if (mode_reg == MODE_LOOKUP)
        begin
            hit = pend_reg && (ent_daddr == ua_reg);
        end
        else
        begin
            hit = pend_reg && ent.free && (ent.size >= size_reg);
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        heap_base_next  = heap_base_reg;
        heap_limit_next = heap_limit_reg;
        max_req_next    = max_req_reg;
        count_next      = count_reg;
        brk_next        = brk_reg;
        free_blk_next   = free_blk_reg;
        free_byte_next  = free_byte_reg;
        byte_tot_next   = byte_tot_reg;
        mode_next       = mode_reg;
        relo_next       = relo_reg;
        scan_idx_next   = scan_idx_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        func_next       = func_reg;
        size_next       = size_reg;
        cnt_next        = cnt_reg;
        ua_next         = ua_reg;
        ovf_next        = ovf_reg;
        chk_idx_next    = chk_idx_reg;
        hit_idx_next    = hit_idx_reg;
        hit_base_next   = hit_base_reg;
        hit_size_next   = hit_size_reg;
        old_idx_next    = old_idx_reg;
        old_base_next   = old_base_reg;
        old_size_next   = old_size_reg;
        old_free_next   = old_free_reg;
        addr_next       = addr_reg;
        st_next         = st_reg;
        out_data_next   = out_data_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = hit_idx_reg;
        ram_wr_data = '{free: 1'b0, size: hit_size_reg, base: hit_base_reg};
        ram_rd_en   = 1'b0;
        ram_rd_addr = scan_idx_reg[IDX_W-1:0];

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_HEAP_BASE:
                begin
                    heap_base_next = cfg_wdata;
                    if (count_reg == '0)
                    begin
                        brk_next = cfg_wdata;
                    end
                end
                CFG_HEAP_LIMIT:  heap_limit_next = cfg_wdata;
                CFG_MAX_REQUEST: max_req_next    = cfg_wdata;
                default:         ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next  = s_tuser;
                    size_next  = req.req_size;
                    cnt_next   = req.elem_count;
                    ua_next    = req.user_addr;
                    ovf_next   = 1'b0;
                    st_next    = ST_OK;
                    addr_next  = '0;
                    relo_next  = 1'b0;
                    mode_next  = MODE_ALLOC;
                    state_next = (s_tuser == FN_CALLOC) ? S_MUL : S_CHECK;
                end
            end

            S_MUL:
            begin
                size_next  = prod[31:0];
                ovf_next   = |prod[63:32];
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                scan_idx_next = '0;
                pend_next     = 1'b0;
                if (func_reg == FN_FREE)
                begin
                    if (ua_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mode_next  = MODE_LOOKUP;
                        state_next = S_SCAN;
                    end
                end
                else if (!size_ok)
                begin
                    st_next    = ST_BAD_SIZE;
                    state_next = S_DONE;
                end
                else if ((func_reg == FN_REALLOC) && (ua_reg != '0))
                begin
                    mode_next  = MODE_LOOKUP;
                    state_next = S_SCAN;
                end
                else
                begin
                    mode_next  = MODE_ALLOC;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    pend_next = 1'b0;
                    if (mode_reg == MODE_LOOKUP)
                    begin
                        old_idx_next  = chk_idx_reg;
                        old_base_next = ent.base;
                        old_size_next = ent.size;
                        old_free_next = ent.free;
                        if (func_reg == FN_FREE)
                        begin
                            state_next = S_FREE_OLD;
                        end
                        else if (ent.size >= size_reg)
                        begin
                            addr_next  = ua_reg;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            // block too small: look for a new one
                            mode_next     = MODE_ALLOC;
                            relo_next     = 1'b1;
                            scan_idx_next = '0;
                        end
                    end
                    else
                    begin
                        hit_idx_next  = chk_idx_reg;
                        hit_base_next = ent.base;
                        hit_size_next = ent.size;
                        state_next    = S_REUSE;
                    end
                end
                else if (more)
                begin
                    ram_rd_en     = 1'b1;
                    pend_next     = 1'b1;
                    chk_idx_next  = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (mode_reg == MODE_LOOKUP)
                    begin
                        st_next    = ST_UNKNOWN;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_APPEND;
                    end
                end
            end

            S_REUSE:
            begin
                ram_wr_en      = 1'b1;
                free_blk_next  = free_blk_reg - CNT_W'(1);
                free_byte_next = free_byte_reg - hit_size_reg;
                addr_next      = (hit_base_reg + 32'(HEADER_BYTES)) & ADDR_MASK[31:0];
                state_next     = relo_reg ? S_FREE_OLD : S_DONE;
            end

            S_APPEND:
            begin
                if ((new_brk > NB_W'(heap_limit_reg)) || (new_brk > ADDR_MASK[NB_W-1:0]))
                begin
                    st_next    = ST_EXHAUSTED;
                    state_next = S_DONE;
                end
                else if (count_reg == CNT_W'(MAX_BLOCKS))
                begin
                    st_next    = ST_TABLE_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    ram_wr_en     = 1'b1;
                    ram_wr_addr   = count_reg[IDX_W-1:0];
                    ram_wr_data   = '{free: 1'b0, size: size_reg, base: brk_reg};
                    count_next    = count_reg + CNT_W'(1);
                    byte_tot_next = byte_tot_reg + size_reg;
                    brk_next      = new_brk[31:0];
                    addr_next     = (brk_reg + 32'(HEADER_BYTES)) & ADDR_MASK[31:0];
                    state_next    = relo_reg ? S_FREE_OLD : S_DONE;
                end
            end

            S_FREE_OLD:
            begin
                ram_wr_addr = old_idx_reg;
                ram_wr_data = '{free: 1'b1, size: old_size_reg, base: old_base_reg};
                if (!old_free_reg)
                begin
                    ram_wr_en      = 1'b1;
                    free_blk_next  = free_blk_reg + CNT_W'(1);
                    free_byte_next = free_byte_reg + old_size_reg;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_data_next.pad          = '0;
                    out_data_next.result_addr  = addr_reg;
                    out_data_next.status       = st_reg;
                    out_data_next.free_blocks  = 7'(free_blk_reg);
                    out_data_next.free_bytes   = free_byte_reg;
                    out_data_next.total_blocks = 7'(count_reg);
                    out_data_next.total_bytes  = byte_tot_reg;
                    out_data_next.header_bytes = 12'(count_reg * HEADER_BYTES);
                    out_valid_next             = 1'b1;
                    state_next                 = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            heap_base_reg  <= HEAP_BASE_RST;
            heap_limit_reg <= HEAP_LIMIT_RST;
            max_req_reg    <= MAX_REQUEST_RST;
            count_reg      <= '0;
            brk_reg        <= HEAP_BASE_RST;
            free_blk_reg   <= '0;
            free_byte_reg  <= '0;
            byte_tot_reg   <= '0;
            mode_reg       <= MODE_ALLOC;
            relo_reg       <= 1'b0;
            scan_idx_reg   <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            heap_base_reg  <= heap_base_next;
            heap_limit_reg <= heap_limit_next;
            max_req_reg    <= max_req_next;
            count_reg      <= count_next;
            brk_reg        <= brk_next;
            free_blk_reg   <= free_blk_next;
            free_byte_reg  <= free_byte_next;
            byte_tot_reg   <= byte_tot_next;
            mode_reg       <= mode_next;
            relo_reg       <= relo_next;
            scan_idx_reg   <= scan_idx_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        size_reg     <= size_next;
        cnt_reg      <= cnt_next;
        ua_reg       <= ua_next;
        ovf_reg      <= ovf_next;
        chk_idx_reg  <= chk_idx_next;
        hit_idx_reg  <= hit_idx_next;
        hit_base_reg <= hit_base_next;
        hit_size_reg <= hit_size_next;
        old_idx_reg  <= old_idx_next;
        old_base_reg <= old_base_next;
        old_size_reg <= old_size_next;
        old_free_reg <= old_free_next;
        addr_reg     <= addr_next;
        st_reg       <= st_next;
        out_data_reg <= out_data_next;
    end

    // free blocks are a subset of the table
    a_free_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        free_blk_reg <= count_reg)
        else $error("free block count above table count");

    // the table only grows, one block at a time
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("table count changed by other than one");

    // a pending table read always points inside the table
    a_pend_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (CNT_W'(chk_idx_reg) < count_reg))
        else $error("scan read beyond table end");

endmodule

// ----- src/ffba_ram.sv -----
// ----------------------------------------------------------------------------
// ffba_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ffba_ram #(
    parameter  int WIDTH = 65,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
